FILE: hw/rtl/sukt_pkg.sv
// Shared types and constants for the sorted unique-key table.
`default_nettype none
package sukt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_W = 32;
  localparam int HANDLE_W = 32;
  localparam int ENTRY_COUNT_W = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_DUP = 2'd1;
  localparam logic [1:0] STAT_MISSING = 2'd2;
  localparam logic [1:0] STAT_FULL = 2'd3;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_EXEC
  } seq_state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0] record_handle;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [HANDLE_W-1:0] found_handle;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } result_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic rem;
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0] handle;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sukt_stream_if.sv
// Valid/ready word channel.
`default_nettype none
interface sukt_stream_if #(
  parameter type word_t = logic
) ();
  logic valid;
  logic ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sukt_cell.sv
// One table slot: holds a key and handle, compares, shifts with its neighbors.
`default_nettype none
module sukt_cell #(
  parameter int TABLE_DEPTH = sukt_pkg::TABLE_DEPTH_DEF,
  parameter int IDX = 0,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic clk,
  input  logic [CW-1:0] count,
  input  sukt_pkg::cell_cmd_t cmd,
  input  logic left_lt,
  input  logic signed [sukt_pkg::KEY_W-1:0] left_key,
  input  logic [sukt_pkg::HANDLE_W-1:0] left_handle,
  input  logic signed [sukt_pkg::KEY_W-1:0] right_key,
  input  logic [sukt_pkg::HANDLE_W-1:0] right_handle,
  output logic signed [sukt_pkg::KEY_W-1:0] key,
  output logic [sukt_pkg::HANDLE_W-1:0] handle,
  output logic lt,
  output logic eq
);

  logic occupied;

  assign occupied = CW'(IDX) < count;
  assign lt = occupied && (key < cmd.key);
  assign eq = occupied && (key == cmd.key);

  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      if (left_lt) begin
        key <= cmd.key;
        handle <= cmd.handle;
      end else begin
        key <= left_key;
        handle <= left_handle;
      end
    end else if (cmd.rem && !lt) begin
      key <= right_key;
      handle <= right_handle;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sorted_unique_key_table.sv
// Top level: sequencer, result register and the row of table cells.
// An accepted item is registered and executed; its result word is registered when it commits.
// The accept/execute sequencer takes no new item until the last one has committed;
// the whole cell row compares and shifts in the execute state.
// A stalled result word holds the sequencer in execute until it is taken.
// Reset empties the table (count to zero); cell contents are left as they are.
`default_nettype none
module sorted_unique_key_table #(
  parameter int TABLE_DEPTH = sukt_pkg::TABLE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  sukt_stream_if.sink items,
  sukt_stream_if.source results
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  sukt_pkg::seq_state_t state, state_next;
  sukt_pkg::item_t item;
  sukt_pkg::cell_cmd_t cmd;
  logic [CW-1:0] count, count_next;
  logic commit;
  logic hit, full;
  logic ins_ok, rem_ok;
  logic [1:0] status;
  logic [sukt_pkg::HANDLE_W-1:0] found;
  logic [TABLE_DEPTH-1:0] lt, eq;
  logic signed [sukt_pkg::KEY_W-1:0] cell_key [TABLE_DEPTH];
  logic [sukt_pkg::HANDLE_W-1:0] cell_handle [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sukt_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    items.ready = 1'b0;
    commit = 1'b0;
    unique case (state)
      sukt_pkg::SEQ_IDLE: begin
        items.ready = !rst;
        if (items.valid) begin
          state_next = sukt_pkg::SEQ_EXEC;
        end
      end
      sukt_pkg::SEQ_EXEC: begin
        if (!results.valid || results.ready) begin
          commit = 1'b1;
          state_next = sukt_pkg::SEQ_IDLE;
        end
      end
      default: state_next = sukt_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      item <= items.word;
    end
  end

  assign hit = |eq;
  assign full = count == CW'(TABLE_DEPTH);

  always_comb begin
    found = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found = found | (cell_handle[i] & {sukt_pkg::HANDLE_W{eq[i]}});
    end
  end

  always_comb begin
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    status = sukt_pkg::STAT_DONE;
    count_next = count;
    unique case (item.mode)
      sukt_pkg::MODE_INSERT: begin
        if (hit) begin
          status = sukt_pkg::STAT_DUP;
        end else if (full) begin
          status = sukt_pkg::STAT_FULL;
        end else begin
          ins_ok = 1'b1;
          count_next = count + CW'(1);
        end
      end
      sukt_pkg::MODE_FIND: begin
        if (!hit) begin
          status = sukt_pkg::STAT_MISSING;
        end
      end
      sukt_pkg::MODE_REMOVE: begin
        if (hit) begin
          rem_ok = 1'b1;
          count_next = count - CW'(1);
        end else begin
          status = sukt_pkg::STAT_MISSING;
        end
      end
      default: ;
    endcase
  end

  assign cmd.ins = commit && ins_ok;
  assign cmd.rem = commit && rem_ok;
  assign cmd.key = item.key;
  assign cmd.handle = item.record_handle;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (commit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      results.word.status <= status;
      results.word.found_handle <=
        ((item.mode == sukt_pkg::MODE_FIND) || (item.mode == sukt_pkg::MODE_REMOVE))
        ? found : '0;
      results.word.entry_count <= sukt_pkg::ENTRY_COUNT_W'(count_next);
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic left_lt;
    logic signed [sukt_pkg::KEY_W-1:0] left_key, right_key;
    logic [sukt_pkg::HANDLE_W-1:0] left_handle, right_handle;

    if (i == 0) begin : g_head
      assign left_lt = 1'b1;
      assign left_key = item.key;
      assign left_handle = item.record_handle;
    end else begin : g_body
      assign left_lt = lt[i-1];
      assign left_key = cell_key[i-1];
      assign left_handle = cell_handle[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
      assign right_handle = cell_handle[i];
    end else begin : g_link
      assign right_key = cell_key[i+1];
      assign right_handle = cell_handle[i+1];
    end

    sukt_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IDX(i)
    ) u_cell (
      .clk(clk),
      .count(count),
      .cmd(cmd),
      .left_lt(left_lt),
      .left_key(left_key),
      .left_handle(left_handle),
      .right_key(right_key),
      .right_handle(right_handle),
      .key(cell_key[i]),
      .handle(cell_handle[i]),
      .lt(lt[i]),
      .eq(eq[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_keys_unique: assert property (@(posedge clk) disable iff (rst)
    (state == sukt_pkg::SEQ_EXEC) |-> $onehot0(eq))
    else $error("more than one cell matches the key");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not add one entry");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.rem |=> count == $past(count) - CW'(1))
    else $error("remove did not drop one entry");

  a_commit_gives_word: assert property (@(posedge clk) disable iff (rst)
    commit |=> results.valid && (state == sukt_pkg::SEQ_IDLE))
    else $error("committed item produced no result word");

endmodule
`default_nettype wire
